// File: src/fpma_pkg.sv
`timescale 1ns / 1ps
// Shared widths for the fixed-point moving average core.
// No dependencies.
package fpma_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int SUM_WIDTH    = 32;

   typedef logic [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [SUM_WIDTH-1:0]    sum_type;

endpackage

// File: src/fixed_point_moving_average_core.sv
`timescale 1ns / 1ps
// Power-of-two boxcar moving average over a ring memory of recent samples.
// Depends on fpma_pkg for widths and types.
//
// One average comes out per accepted sample. The core sustains one item per clock cycle
// while the result side does not stall. An accepted sample is registered in the compute stage
// with the oldest sample read from the ring; its average is then registered onto the rsp_
// ports. The rate is set by the ring memory, with one read (the oldest sample) and one write
// (the new sample) per cycle, and by the single 32-bit add or subtract on the sum per cycle.
// The window memory is not cleared after reset: until the pointer has gone once around
// the ring, the oldest sample reads as zero, so items are accepted right out of reset.
// The sum wraps modulo 2^32 and the average is its low 16 bits above FRAC_BITS.
module fixed_point_moving_average_core #(
   parameter int WINDOW_LOG2 = 4,
   parameter int FRAC_BITS   = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [fpma_pkg::SAMPLE_WIDTH-1:0]  req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [fpma_pkg::SAMPLE_WIDTH-1:0]  rsp_average
);
   import fpma_pkg::*;

   localparam int DEPTH = 1 << WINDOW_LOG2;
   localparam logic [WINDOW_LOG2-1:0] LAST_SLOT = '1;

   typedef logic [WINDOW_LOG2-1:0] slot_type;

   sample_type mem [DEPTH];

   slot_type   ptr_ff;
   logic       filled_ff;

   logic       s1_valid_ff;
   logic       s1_live_ff;
   slot_type   s1_slot_ff;
   sample_type s1_sample_ff;
   sample_type rd_data_ff;

   sum_type    sum_ff;
   sum_type    sum_in;

   logic       rsp_valid_ff;
   sample_type rsp_average_ff;

   logic       req_fire;
   logic       out_free;
   logic       s1_adv;

   sample_type old_sample;
   sum_type    scaled_new;
   sum_type    scaled_old;
   sum_type    delta_up;
   sum_type    delta_down;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

   // oldest sample counts as zero on the first lap
   assign old_sample = s1_live_ff ? rd_data_ff : '0;
   assign scaled_new = sum_type'(s1_sample_ff) << FRAC_BITS;
   assign scaled_old = sum_type'(old_sample) << FRAC_BITS;
   assign delta_up   = (scaled_new - scaled_old) >> WINDOW_LOG2;
   assign delta_down = (scaled_old - scaled_new) >> WINDOW_LOG2;

   always_comb begin
      if (scaled_new > scaled_old) begin
         sum_in = sum_ff + delta_up;
      end else begin
         sum_in = sum_ff - delta_down;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         mem[s1_slot_ff] <= s1_sample_ff;
      end
      if (req_fire) begin
         rd_data_ff <= mem[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         filled_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            ptr_ff <= ptr_ff + 1'b1;
            if (ptr_ff == LAST_SLOT) begin
               filled_ff <= 1'b1;
            end
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            sum_ff       <= sum_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_sample_ff <= req_sample;
         s1_slot_ff   <= ptr_ff;
         s1_live_ff   <= filled_ff;
      end
      if (s1_adv) begin
         rsp_average_ff <= sum_in[FRAC_BITS +: SAMPLE_WIDTH];
      end
   end

   // write-back and the next read never hit the same entry
   assert property (@(posedge clock) disable iff (reset)
      (s1_adv && req_fire) |-> (s1_slot_ff != ptr_ff))
      else $error("ring write and read collide");

   // item held in the compute stage is always the one just behind the pointer
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (slot_type'(s1_slot_ff + 1'b1) == ptr_ff))
      else $error("compute stage slot out of step with pointer");

   // a stalled compute stage blocks new items
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("item accepted over a stalled stage");

   // once the ring has wrapped it stays filled
   assert property (@(posedge clock) disable iff (reset)
      filled_ff |=> filled_ff)
      else $error("fill flag dropped");

   // running sum moves only when a result is produced
   assert property (@(posedge clock) disable iff (reset)
      !s1_adv |=> $stable(sum_ff))
      else $error("running sum changed without an item");

endmodule
